FILE: rtl/least_prime_factor_sieve_assert.svh
// Assertion macros for the least prime factor sieve.
// Each macro expands to one labelled concurrent assertion, clocked on clk_i and
// switched off while rst_ni is low.
`ifndef LEAST_PRIME_FACTOR_SIEVE_ASSERT_SVH
`define LEAST_PRIME_FACTOR_SIEVE_ASSERT_SVH

// Same-cycle implication.
`define LPFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lpfs_pkg.sv
`timescale 1ns / 1ps
package lpfs_pkg;

  // Default sizes of the factor store and the prime list.
  localparam int unsigned MaxNDefault       = 65536;
  localparam int unsigned PrimeDepthDefault = 8192;

  // Fixed widths of the configuration register and of the result fields.
  localparam int unsigned LimitWidth = 17;
  localparam int unsigned NumWidth   = 16;

  localparam logic [LimitWidth-1:0] LimitReset = 17'h10000;

endpackage

FILE: rtl/least_prime_factor_sieve.sv
`timescale 1ns / 1ps
// Linear (Euler) sieve that produces the numbers 2, 3, 4, ... in rising order, one number for
// each start_i pulse taken while busy_o is low, each with its least prime factor and a prime
// flag. The result is shown for exactly one cycle with result_valid_o high; the receiver cannot
// stall it, so it must capture the result in that cycle. A request with restart_i high first
// clears the factor store and the prime list and begins again at two. Once every number below
// the limit register has been produced, each further request gives a single result with
// finished_o high and zeros elsewhere. The block works on one request at a time and holds
// busy_o high until it is done. A request that finds the sweep finished passes only the range
// check. A live number passes the range check and the factor lookup and then walks the prime
// list, marking k composites, until a prime exceeds its least factor, a product reaches the
// limit or the prime list runs out. Each marked composite passes the registered read of the
// prime list, the shared multiplier and the write into the factor store. Each composite is
// marked only once, so k averages just under one. After reset the factor store is swept to
// zero, one entry a cycle. A restart sweeps only the entries up to the highest one written
// since the previous clear. During either sweep busy_o stays high, but limit writes are still
// taken.
module least_prime_factor_sieve
  import lpfs_pkg::*;
#(
  parameter int unsigned MAX_N       = MaxNDefault,
  parameter int unsigned PRIME_DEPTH = PrimeDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Limit register write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LimitWidth-1:0] cfg_limit_i,
  // Request side.
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  restart_i,
  // Result side.
  output logic                  result_valid_o,
  output logic [NumWidth-1:0]   number_o,
  output logic [NumWidth-1:0]   least_factor_o,
  output logic                  is_prime_o,
  output logic                  finished_o
);

  // Widths that follow from the store sizes.
  localparam int unsigned AW  = $clog2(MAX_N);            // store index and factor width
  localparam int unsigned CW  = $clog2(MAX_N + 1);        // holds MAX_N itself
  localparam int unsigned LW  = (CW > LimitWidth) ? CW : LimitWidth;
  localparam int unsigned MW  = 2 * AW;                   // product width
  localparam int unsigned PAW = (PRIME_DEPTH > 1) ? $clog2(PRIME_DEPTH) : 1;
  localparam int unsigned PW  = $clog2(PRIME_DEPTH + 1);  // prime count

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_FACTOR = 3'd3;
  localparam logic [2:0] S_PREAD  = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_MARK   = 3'd6;

  logic [2:0] state_q, state_d;

  // The sweep state proper.
  logic [CW-1:0]   cur_q, cur_d;          // current number
  logic [PW-1:0]   cnt_q, cnt_d;          // primes held in the list
  logic [PW-1:0]   j_q, j_d;              // walk position in the prime list
  logic [AW-1:0]   lp_q, lp_d;            // least factor of the current number
  logic [MW-1:0]   m_q, m_d;              // candidate composite
  logic [AW-1:0]   p_q, p_d;              // prime that would mark it

  // Clearing of the factor store: hwm_q is one past the highest entry written since the
  // last clear, so a restart only sweeps what it has to.
  logic [CW-1:0]   hwm_q, hwm_d;
  logic [CW-1:0]   clr_q, clr_d;
  logic [CW-1:0]   clr_inc;
  logic [CW-1:0]   m_inc;
  logic            pend_q, pend_d;        // a request waits behind the clear

  logic [LimitWidth-1:0] limit_q;
  logic [LW-1:0]         eff_lim;

  // Result register.
  logic                valid_q, valid_d;
  logic [NumWidth-1:0] num_q, num_d;
  logic [NumWidth-1:0] lf_q, lf_d;
  logic                prime_q, prime_d;
  logic                fin_q, fin_d;

  // Factor store and prime list.
  logic [AW-1:0] sf_mem [MAX_N];
  logic [AW-1:0] sf_rd_q;
  logic          sf_we;
  logic [AW-1:0] sf_wa;
  logic [AW-1:0] sf_wd;

  logic [AW-1:0] pl_mem [PRIME_DEPTH];
  logic [AW-1:0] pl_rd_q;
  logic          pl_we;

  logic accept;

  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  // Limits above the store size saturate to the store size.
  assign eff_lim = (LW'(limit_q) > LW'(MAX_N)) ? LW'(MAX_N) : LW'(limit_q);

  assign clr_inc = clr_q + 1'b1;
  assign m_inc   = CW'(m_q[AW-1:0]) + 1'b1;

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    j_d     = j_q;
    lp_d    = lp_q;
    m_d     = m_q;
    p_d     = p_q;
    hwm_d   = hwm_q;
    clr_d   = clr_q;
    pend_d  = pend_q;
    valid_d = 1'b0;
    num_d   = num_q;
    lf_d    = lf_q;
    prime_d = prime_q;
    fin_d   = fin_q;
    sf_we   = 1'b0;
    sf_wa   = m_q[AW-1:0];
    sf_wd   = p_q;
    pl_we   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (restart_i) begin
            cur_d = CW'(2);
            cnt_d = '0;
            if (hwm_q != '0) begin
              clr_d   = '0;
              pend_d  = 1'b1;
              state_d = S_CLEAR;
            end else begin
              state_d = S_CHECK;
            end
          end else begin
            state_d = S_CHECK;
          end
        end
      end

      S_CLEAR: begin
        sf_we = 1'b1;
        sf_wa = clr_q[AW-1:0];
        sf_wd = '0;
        clr_d = clr_inc;
        if (clr_inc == hwm_q) begin
          hwm_d   = '0;
          pend_d  = 1'b0;
          state_d = pend_q ? S_CHECK : S_IDLE;
        end
      end

      S_CHECK: begin
        // The store read of the current number is under way in this cycle.
        if (LW'(cur_q) >= eff_lim) begin
          valid_d = 1'b1;
          num_d   = '0;
          lf_d    = '0;
          prime_d = 1'b0;
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_FACTOR;
        end
      end

      S_FACTOR: begin
        if (sf_rd_q == '0) begin
          // Never marked, so prime. Its own entry is never read again in this sweep.
          lp_d    = cur_q[AW-1:0];
          prime_d = 1'b1;
          if (cnt_q < PW'(PRIME_DEPTH)) begin
            pl_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          lp_d    = sf_rd_q;
          prime_d = 1'b0;
        end
        valid_d = 1'b1;
        fin_d   = 1'b0;
        num_d   = NumWidth'(32'(cur_q));
        lf_d    = NumWidth'(32'(lp_d));
        j_d     = '0;
        state_d = S_PREAD;
      end

      S_PREAD: begin
        if (j_q < cnt_q) begin
          state_d = S_MUL;
        end else begin
          cur_d   = cur_q + 1'b1;
          state_d = S_IDLE;
        end
      end

      S_MUL: begin
        p_d     = pl_rd_q;
        m_d     = MW'(cur_q[AW-1:0]) * MW'(pl_rd_q);
        state_d = S_MARK;
      end

      S_MARK: begin
        if ((p_q > lp_q) || (m_q >= MW'(eff_lim))) begin
          cur_d   = cur_q + 1'b1;
          state_d = S_IDLE;
        end else begin
          sf_we = 1'b1;
          j_d   = j_q + 1'b1;
          if (m_inc > hwm_q) begin
            hwm_d = m_inc;
          end
          state_d = S_PREAD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cur_q   <= CW'(2);
      cnt_q   <= '0;
      j_q     <= '0;
      hwm_q   <= CW'(MAX_N);
      clr_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
      limit_q <= LimitReset;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      j_q     <= j_d;
      hwm_q   <= hwm_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lp_q    <= lp_d;
    m_q     <= m_d;
    p_q     <= p_d;
    num_q   <= num_d;
    lf_q    <= lf_d;
    prime_q <= prime_d;
    fin_q   <= fin_d;
  end

  // Factor store: one write port, one registered read of the current number.
  always_ff @(posedge clk_i) begin
    if (sf_we) begin
      sf_mem[sf_wa] <= sf_wd;
    end
    sf_rd_q <= sf_mem[cur_q[AW-1:0]];
  end

  // Prime list: appended at the fill count, read at the walk position.
  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      pl_mem[cnt_q[PAW-1:0]] <= cur_q[AW-1:0];
    end
    pl_rd_q <= pl_mem[j_q[PAW-1:0]];
  end

  assign result_valid_o = valid_q;
  assign number_o       = num_q;
  assign least_factor_o = lf_q;
  assign is_prime_o     = prime_q;
  assign finished_o     = fin_q;

`include "least_prime_factor_sieve_assert.svh"

  // A result only ever follows the range check or the factor lookup.
  `LPFS_ASSERT_NOW(a_result_source, valid_q, ($past(state_q) == S_CHECK) || ($past(state_q) == S_FACTOR), "result strobe without a lookup")
  // A finished result carries no number.
  `LPFS_ASSERT_NOW(a_finished_zero, valid_q && fin_q, (num_q == '0) && (lf_q == '0) && !prime_q, "finished result with payload")
  // The prime list never holds more entries than it has room for.
  `LPFS_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= PW'(PRIME_DEPTH), "prime count beyond list depth")
  // The multiplier is only fed from a valid list entry.
  `LPFS_ASSERT_NOW(a_walk_bound, state_q == S_MUL, j_q < cnt_q, "prime walk beyond the list")
  // A taken request always makes the block busy in the next cycle.
  `LPFS_ASSERT_NEXT(a_busy_after_accept, accept, busy_o, "request taken but block not busy")

endmodule
